@@ rtl/core/ergf_pkg.sv @@
// ergf_pkg: shared types and codes for the episode return group filter
// holds request/result payloads, the sweep token and the ranking ring types
// no dependencies
package ergf_pkg;

  // request mode codes
  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_ACCUM    = 2'd1;
  localparam logic [1:0] MODE_FINALIZE = 2'd2;
  localparam logic [1:0] MODE_CLASSIFY = 2'd3;

  // filter mode codes
  localparam logic [1:0] FILT_ALL   = 2'd0;
  localparam logic [1:0] FILT_FLOOR = 2'd1;
  localparam logic [1:0] FILT_TOP   = 2'd2;
  localparam logic [1:0] FILT_RANGE = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_BAD_CFG   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE    = 2'd0;
  localparam logic [1:0] CFG_RETURN_FLOOR   = 2'd1;
  localparam logic [1:0] CFG_RETURN_CEILING = 2'd2;
  localparam logic [1:0] CFG_TOP_COUNT      = 2'd3;

  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [30:0]        env_id;
    logic [30:0]        episode_id;
    logic signed [31:0] reward_value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         episode_slot;
    logic               keep;
    logic [16:0]        episode_rows;
    logic signed [47:0] ep_return;
    logic [8:0]         episode_total;
    logic [8:0]         selected_total;
  } result_t;

  typedef enum logic [1:0] {
    TOK_ACC,
    TOK_CLS,
    TOK_FSEL,
    TOK_FTOP
  } tok_op_t;

  // token that walks the cell chain once per request that sweeps the table
  typedef struct packed {
    logic               valid;
    tok_op_t            op;
    logic [30:0]        env;
    logic [30:0]        epi;
    logic signed [31:0] reward;
    logic               found;
    logic               fresh;
    logic               keep;
    logic [7:0]         slot;
    logic [16:0]        rows;
    logic signed [47:0] ret;
    logic [8:0]         count;
  } token_t;

  // value rotating around the ranking ring
  typedef struct packed {
    logic               valid;
    logic signed [47:0] ret;
  } circ_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [47:0] floor;
    logic signed [47:0] ceiling;
    logic [8:0]         top_count;
  } filt_cfg_t;

  typedef struct packed {
    logic clear_sel;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/core/ergf_cell.sv @@
// ergf_cell: one table slot of the episode return group filter
// matches the passing token, updates its entry, ranks against the ring
// depends on ergf_pkg
module ergf_cell #(
  parameter int INDEX      = 0,
  parameter int SLOT_COUNT = 256,
  parameter int MAX_ROWS   = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [$clog2(SLOT_COUNT+1)-1:0] used,
  input  ergf_pkg::filt_cfg_t cfg,
  input  ergf_pkg::cell_ctl_t ctl,
  input  ergf_pkg::token_t    tok_in,
  output ergf_pkg::token_t    tok_out,
  input  ergf_pkg::circ_t     circ_in,
  input  logic [$clog2(SLOT_COUNT)-1:0] idx_in,
  output ergf_pkg::circ_t     circ,
  output logic [$clog2(SLOT_COUNT)-1:0] circ_idx
);

  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic [30:0]        env, env_next;
  logic [30:0]        epi, epi_next;
  logic [RW-1:0]      rows, rows_next;
  logic signed [47:0] ret, ret_next;
  logic               sel, sel_next;
  logic [UW-1:0]      ahead;
  ergf_pkg::token_t   tok_next;

  logic               active, is_next, hit, pick;
  logic signed [48:0] sum;
  logic signed [47:0] sat_ret;
  logic [RW-1:0]      rows_inc;

  always_comb begin
    active   = tok_in.valid && (UW'(INDEX) < used);
    is_next  = tok_in.valid && (UW'(INDEX) == used) && !tok_in.found;
    hit      = active && !tok_in.found && (env == tok_in.env) && (epi == tok_in.epi);
    sum      = {ret[47], ret} + {{17{tok_in.reward[31]}}, tok_in.reward};
    if (sum[48] != sum[47]) begin
      sat_ret = sum[48] ? ergf_pkg::S48_MIN : ergf_pkg::S48_MAX;
    end else begin
      sat_ret = sum[47:0];
    end
    rows_inc = (rows < RW'(MAX_ROWS)) ? rows + RW'(1) : rows;
    pick     = 1'b0;
    tok_next = tok_in;
    env_next = env;
    epi_next = epi;
    rows_next = rows;
    ret_next  = ret;
    sel_next  = sel;
    case (tok_in.op)
      ergf_pkg::TOK_ACC: begin
        if (hit) begin
          rows_next = rows_inc;
          ret_next  = sat_ret;
        end else if (is_next) begin
          env_next  = tok_in.env;
          epi_next  = tok_in.epi;
          rows_next = RW'(1);
          ret_next  = {{16{tok_in.reward[31]}}, tok_in.reward};
          sel_next  = 1'b0;
          tok_next.fresh = 1'b1;
        end
        if (hit || is_next) begin
          tok_next.found = 1'b1;
          tok_next.slot  = 8'(INDEX);
          tok_next.rows  = 17'(rows_next);
          tok_next.ret   = ret_next;
        end
      end
      ergf_pkg::TOK_CLS: begin
        if (hit) begin
          tok_next.found = 1'b1;
          tok_next.slot  = 8'(INDEX);
          tok_next.keep  = sel;
          tok_next.rows  = 17'(rows);
          tok_next.ret   = ret;
        end
      end
      ergf_pkg::TOK_FSEL: begin
        unique case (cfg.mode)
          ergf_pkg::FILT_FLOOR: pick = ret >= cfg.floor;
          ergf_pkg::FILT_RANGE: pick = (ret >= cfg.floor) && (ret <= cfg.ceiling);
          default:              pick = 1'b1;
        endcase
        if (active) begin
          sel_next = pick;
          tok_next.count = tok_in.count + 9'(pick);
        end
      end
      default: begin
        pick = 32'(ahead) < 32'(cfg.top_count);
        if (active) begin
          sel_next = pick;
          tok_next.count = tok_in.count + 9'(pick);
        end
      end
    endcase
    if (!tok_in.valid) begin
      env_next  = env;
      epi_next  = epi;
      rows_next = rows;
      ret_next  = ret;
      sel_next  = sel;
    end
    if (ctl.clear_sel) begin
      sel_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    env  <= env_next;
    epi  <= epi_next;
    rows <= rows_next;
    ret  <= ret_next;
    if (ctl.load) begin
      circ.valid <= UW'(INDEX) < used;
      circ.ret   <= ret;
      circ_idx   <= IW'(INDEX);
      ahead      <= '0;
    end else if (ctl.shift) begin
      circ     <= circ_in;
      circ_idx <= idx_in;
      if (circ_in.valid &&
          ((circ_in.ret > ret) || ((circ_in.ret == ret) && (idx_in < IW'(INDEX))))) begin
        ahead <= ahead + UW'(1);
      end
    end
    if (rst) begin
      sel     <= 1'b0;
      tok_out <= '0;
    end else begin
      sel     <= sel_next;
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/core/episode_return_group_filter.sv @@
// episode_return_group_filter: top level, controller and chain of slot cells
// groups rows by (env_id, episode_id), sums returns, filters episodes
// depends on ergf_pkg and ergf_cell
//
// usage
// - item channel (item_valid/item_ready/item) takes one request: clear,
//   accumulate, finalize or classify; result channel gives one result each
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the four
//   filter registers; always ready, write only while the block is idle
// - accumulate, classify and finalize in the other filter modes send a token
//   down the chain of SLOT_COUNT cells, one cell a cycle; the next request
//   is taken once the result has gone to the output register
// - finalize in top-count mode first rotates all returns around the cell
//   ring, then sends its token down the chain
// - clear and a rejected finalize send no token and go straight to hand-over
// - one request at a time; a request is taken while an earlier result
//   still waits, and a stalled result holds in the output register
// - reset empties the table, clears all selected flags and counts and
//   loads the register reset values; no clearing pass is needed
module episode_return_group_filter #(
  parameter int SLOT_COUNT = 256,
  parameter int MAX_ROWS   = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ergf_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ergf_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_data
);

  localparam int UW = $clog2(SLOT_COUNT + 1);
  localparam int IW = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ROTATE,
    ST_DONE
  } state_t;

  state_t              state;
  logic [UW-1:0]       used;
  logic [8:0]          chosen;
  logic [IW-1:0]       rot_cnt;
  ergf_pkg::result_t   res;
  ergf_pkg::result_t   sweep_res;
  ergf_pkg::result_t   bad_res;
  ergf_pkg::token_t    launch;
  ergf_pkg::filt_cfg_t cfg;
  ergf_pkg::cell_ctl_t ctl;

  ergf_pkg::token_t    tok_w  [0:SLOT_COUNT];
  ergf_pkg::circ_t     circ_w [0:SLOT_COUNT-1];
  logic [IW-1:0]       idx_w  [0:SLOT_COUNT-1];

  logic accept, bad_cfg;
  ergf_pkg::token_t done_tok;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign done_tok   = tok_w[SLOT_COUNT];

  // filter settings that make finalize fail
  assign bad_cfg = ((cfg.mode == ergf_pkg::FILT_TOP) && (cfg.top_count == 9'd0)) ||
                   ((cfg.mode == ergf_pkg::FILT_RANGE) && (cfg.floor > cfg.ceiling));

  always_comb begin
    ctl.clear_sel = accept && (item.mode == ergf_pkg::MODE_CLEAR);
    ctl.load      = accept && (item.mode == ergf_pkg::MODE_FINALIZE) && !bad_cfg &&
                    (cfg.mode == ergf_pkg::FILT_TOP);
    ctl.shift     = (state == ST_ROTATE);
  end

  // result of a rejected finalize: only the status and the totals are reported
  always_comb begin
    bad_res                = '0;
    bad_res.status         = ergf_pkg::STAT_BAD_CFG;
    bad_res.episode_total  = 9'(used);
    bad_res.selected_total = chosen;
  end

  // result built from the token leaving the chain
  always_comb begin
    sweep_res                = '0;
    sweep_res.episode_total  = 9'(used);
    sweep_res.selected_total = chosen;
    case (done_tok.op) inside
      ergf_pkg::TOK_ACC, ergf_pkg::TOK_CLS: begin
        if (done_tok.found) begin
          sweep_res.status       = ergf_pkg::STAT_OK;
          sweep_res.episode_slot = done_tok.slot;
          sweep_res.keep         = done_tok.keep;
          sweep_res.episode_rows = done_tok.rows;
          sweep_res.ep_return    = done_tok.ret;
        end else begin
          sweep_res.status = (done_tok.op == ergf_pkg::TOK_ACC) ?
                             ergf_pkg::STAT_FULL : ergf_pkg::STAT_NOT_FOUND;
        end
        if (done_tok.fresh) begin
          sweep_res.episode_total = 9'(used + UW'(1));
        end
      end
      default: begin
        sweep_res.status         = ergf_pkg::STAT_OK;
        sweep_res.selected_total = done_tok.count;
      end
    endcase
  end

  assign tok_w[0] = launch;

  // the slot cells: token chain left to right, ranking ring closes at cell 0
  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
    localparam int PREV = (k == 0) ? SLOT_COUNT - 1 : k - 1;
    ergf_cell #(
      .INDEX(k),
      .SLOT_COUNT(SLOT_COUNT),
      .MAX_ROWS(MAX_ROWS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .used    (used),
      .cfg     (cfg),
      .ctl     (ctl),
      .tok_in  (tok_w[k]),
      .tok_out (tok_w[k+1]),
      .circ_in (circ_w[PREV]),
      .idx_in  (idx_w[PREV]),
      .circ    (circ_w[k]),
      .circ_idx(idx_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      used          <= '0;
      chosen        <= '0;
      rot_cnt       <= '0;
      launch.valid  <= 1'b0;
      result_valid  <= 1'b0;
      cfg.mode      <= ergf_pkg::FILT_ALL;
      cfg.floor     <= '0;
      cfg.ceiling   <= ergf_pkg::S48_MAX;
      cfg.top_count <= 9'd1;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          ergf_pkg::CFG_FILTER_MODE:    cfg.mode      <= cfg_data[1:0];
          ergf_pkg::CFG_RETURN_FLOOR:   cfg.floor     <= cfg_data;
          ergf_pkg::CFG_RETURN_CEILING: cfg.ceiling   <= cfg_data;
          ergf_pkg::CFG_TOP_COUNT:      cfg.top_count <= cfg_data[8:0];
          default: ;
        endcase
      end

      // output register: load on hand-over, empty once taken
      if ((state == ST_DONE) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      // token is live for a single cycle at the chain head
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            launch.env    <= item.env_id;
            launch.epi    <= item.episode_id;
            launch.reward <= item.reward_value;
            launch.found  <= 1'b0;
            launch.fresh  <= 1'b0;
            launch.keep   <= 1'b0;
            launch.slot   <= '0;
            launch.rows   <= '0;
            launch.ret    <= '0;
            launch.count  <= '0;
            unique case (item.mode)
              ergf_pkg::MODE_CLEAR: begin
                used         <= '0;
                chosen       <= '0;
                res          <= '0;
                launch.valid <= 1'b0;
                state        <= ST_DONE;
              end
              ergf_pkg::MODE_ACCUM: begin
                launch.valid <= 1'b1;
                launch.op    <= ergf_pkg::TOK_ACC;
                state        <= ST_SWEEP;
              end
              ergf_pkg::MODE_FINALIZE: begin
                if (bad_cfg) begin
                  res          <= bad_res;
                  launch.valid <= 1'b0;
                  state        <= ST_DONE;
                end else if (cfg.mode == ergf_pkg::FILT_TOP) begin
                  launch.valid <= 1'b0;
                  rot_cnt      <= '0;
                  state        <= ST_ROTATE;
                end else begin
                  launch.valid <= 1'b1;
                  launch.op    <= ergf_pkg::TOK_FSEL;
                  state        <= ST_SWEEP;
                end
              end
              default: begin
                launch.valid <= 1'b1;
                launch.op    <= ergf_pkg::TOK_CLS;
                state        <= ST_SWEEP;
              end
            endcase
          end else begin
            launch.valid <= 1'b0;
          end
        end
        ST_ROTATE: begin
          // the last shift and the token launch share a cycle
          rot_cnt      <= rot_cnt + IW'(1);
          launch.valid <= (rot_cnt == IW'(SLOT_COUNT - 2));
          if (rot_cnt == IW'(SLOT_COUNT - 2)) begin
            launch.op <= ergf_pkg::TOK_FTOP;
            state     <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          launch.valid <= 1'b0;
          if (done_tok.valid) begin
            state <= ST_DONE;
            res   <= sweep_res;
            if (done_tok.fresh) begin
              used <= used + UW'(1);
            end
            if ((done_tok.op == ergf_pkg::TOK_FSEL) || (done_tok.op == ergf_pkg::TOK_FTOP)) begin
              chosen <= done_tok.count;
            end
          end
        end
        default: begin
          launch.valid <= 1'b0;
          // hand the result over once the output register is free
          if (!result_valid || result_ready) begin
            result <= res;
            state  <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // no token may be in flight while new requests are taken
  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !done_tok.valid && !launch.valid)
    else $error("token in flight while idle");

  // table occupancy never passes the slot count
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(SLOT_COUNT))
    else $error("table occupancy out of range");

  // a launched token lives one cycle at the chain head
  a_launch_pulse: assert property (@(posedge clk) disable iff (rst)
    launch.valid |=> !launch.valid)
    else $error("token launched twice");

  // a token leaving the chain always moves the block to result hand-over
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) && done_tok.valid |=> (state == ST_DONE))
    else $error("sweep end missed");

endmodule

@@ tb/ergf_checker.sv @@
// ergf_checker: watches the request, result and register channels of the
// episode return group filter, predicts each result and compares it
// depends on ergf_pkg
`timescale 1ns / 1ps

module ergf_checker #(
  parameter int SLOT_COUNT = 256,
  parameter int MAX_ROWS   = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  ergf_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  ergf_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  logic [30:0]        tab_env  [SLOT_COUNT];
  logic [30:0]        tab_epi  [SLOT_COUNT];
  logic [16:0]        tab_rows [SLOT_COUNT];
  logic signed [47:0] tab_ret  [SLOT_COUNT];
  logic               tab_sel  [SLOT_COUNT];
  int                 used_cnt;
  int                 sel_cnt;

  logic [1:0]         f_mode;
  logic signed [47:0] f_floor;
  logic signed [47:0] f_ceiling;
  logic [8:0]         f_top;

  ergf_pkg::result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int lookup_slot(logic [30:0] env, logic [30:0] epi);
    for (int i = 0; i < used_cnt; i++)
      if (tab_env[i] == env && tab_epi[i] == epi) return i;
    return -1;
  endfunction

  function automatic logic [1:0] run_selection();
    int cnt;
    int ahead;
    logic sel;
    if (f_mode == ergf_pkg::FILT_TOP && f_top == 0) return ergf_pkg::STAT_BAD_CFG;
    if (f_mode == ergf_pkg::FILT_RANGE && f_floor > f_ceiling) return ergf_pkg::STAT_BAD_CFG;
    cnt = 0;
    for (int i = 0; i < used_cnt; i++) begin
      case (f_mode)
        ergf_pkg::FILT_ALL: sel = 1'b1;
        ergf_pkg::FILT_FLOOR: sel = tab_ret[i] >= f_floor;
        ergf_pkg::FILT_RANGE: sel = tab_ret[i] >= f_floor && tab_ret[i] <= f_ceiling;
        default: begin
          ahead = 0;
          for (int j = 0; j < used_cnt; j++)
            if (tab_ret[j] > tab_ret[i] || (tab_ret[j] == tab_ret[i] && j < i))
              ahead++;
          sel = ahead < f_top;
        end
      endcase
      tab_sel[i] = sel;
      cnt += sel;
    end
    sel_cnt = cnt;
    return ergf_pkg::STAT_OK;
  endfunction

  // one request in, one predicted result out
  function automatic ergf_pkg::result_t predict_result(ergf_pkg::item_t req);
    ergf_pkg::result_t r;
    int s;
    logic signed [49:0] sum;
    r = '0;
    case (req.mode)
      ergf_pkg::MODE_CLEAR: begin
        used_cnt = 0;
        sel_cnt = 0;
        for (int i = 0; i < SLOT_COUNT; i++) tab_sel[i] = 1'b0;
      end
      ergf_pkg::MODE_ACCUM: begin
        s = lookup_slot(req.env_id, req.episode_id);
        if (s < 0 && used_cnt >= SLOT_COUNT) begin
          r.status = ergf_pkg::STAT_FULL;
        end else begin
          if (s < 0) begin
            s = used_cnt;
            used_cnt++;
            tab_env[s] = req.env_id;
            tab_epi[s] = req.episode_id;
            tab_rows[s] = '0;
            tab_ret[s] = '0;
            tab_sel[s] = 1'b0;
          end
          if (tab_rows[s] < MAX_ROWS) tab_rows[s]++;
          sum = 50'(tab_ret[s]) + 50'(req.reward_value);
          if (sum > 50'(ergf_pkg::S48_MAX)) sum = 50'(ergf_pkg::S48_MAX);
          if (sum < 50'(ergf_pkg::S48_MIN)) sum = 50'(ergf_pkg::S48_MIN);
          tab_ret[s] = sum[47:0];
          r.episode_slot = s[7:0];
          r.episode_rows = tab_rows[s];
          r.ep_return = tab_ret[s];
        end
      end
      ergf_pkg::MODE_FINALIZE: r.status = run_selection();
      default: begin
        s = lookup_slot(req.env_id, req.episode_id);
        if (s < 0) begin
          r.status = ergf_pkg::STAT_NOT_FOUND;
        end else begin
          r.episode_slot = s[7:0];
          r.keep = tab_sel[s];
          r.episode_rows = tab_rows[s];
          r.ep_return = tab_ret[s];
        end
      end
    endcase
    r.episode_total = used_cnt[8:0];
    r.selected_total = sel_cnt[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    ergf_pkg::result_t want;
    if (rst) begin
      used_cnt <= 0;
      sel_cnt <= 0;
      f_mode <= ergf_pkg::FILT_ALL;
      f_floor <= '0;
      f_ceiling <= ergf_pkg::S48_MAX;
      f_top <= 9'd1;
      fail_count <= 0;
      for (int i = 0; i < SLOT_COUNT; i++) tab_sel[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ergf_pkg::CFG_FILTER_MODE: f_mode = cfg_data[1:0];
          ergf_pkg::CFG_RETURN_FLOOR: f_floor = cfg_data;
          ergf_pkg::CFG_RETURN_CEILING: f_ceiling = cfg_data;
          ergf_pkg::CFG_TOP_COUNT: f_top = cfg_data[8:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.episode_slot !== want.episode_slot)
            report_mismatch("episode_slot", result.episode_slot, want.episode_slot);
          if (result.keep !== want.keep)
            report_mismatch("keep", result.keep, want.keep);
          if (result.episode_rows !== want.episode_rows)
            report_mismatch("episode_rows", result.episode_rows, want.episode_rows);
          if (result.ep_return !== want.ep_return)
            report_mismatch("ep_return", result.ep_return, want.ep_return);
          if (result.episode_total !== want.episode_total)
            report_mismatch("episode_total", result.episode_total, want.episode_total);
          if (result.selected_total !== want.selected_total)
            report_mismatch("selected_total", result.selected_total,
                            want.selected_total);
        end
      end
      if (item_valid && item_ready) expected_results.push_back(predict_result(item));
    end
  end
endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for the episode return group filter
// drives requests, register writes and result backpressure; ergf_checker does the checking
// depends on ergf_pkg, episode_return_group_filter and ergf_checker
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  ergf_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  ergf_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [47:0]       cfg_data;
  int                fail_count;
  int                pending;

  // stall control for the result side
  bit                calm;
  int                idle_cycles;

  episode_return_group_filter dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ergf_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // watchdog: counts cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result backpressure: random stall bursts, none once calm is set
  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // send one request at the next falling edge, optionally after an idle
  // burst; returns at the accepting edge with valid still high
  task automatic send_request(logic [1:0] mode, logic [30:0] env, logic [30:0] epi,
                              logic [31:0] reward);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item.mode <= mode;
    item.env_id <= env;
    item.episode_id <= epi;
    item.reward_value <= reward;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // drop the request valid after the last accepted request
  task automatic idle_input();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  // wait for all results, then for the longest sweep
  task automatic drain();
    idle_input();
    while (pending != 0) @(negedge clk);
    repeat (2 * 256 + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_filter(logic [1:0] fm, logic [47:0] lo, logic [47:0] hi,
                            logic [8:0] top);
    drain();
    write_reg(ergf_pkg::CFG_FILTER_MODE, {46'd0, fm});
    write_reg(ergf_pkg::CFG_RETURN_FLOOR, lo);
    write_reg(ergf_pkg::CFG_RETURN_CEILING, hi);
    write_reg(ergf_pkg::CFG_TOP_COUNT, {39'd0, top});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_reward();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // a table-building episode: clear, rows over a small key pool with an occasional
  // random request, then finalize and classify; pool keys sometimes use high bits for full coverage
  task automatic run_episode_set(int rows, int pool);
    logic [30:0] envs[16];
    logic [30:0] epis[16];
    int k;
    for (int i = 0; i < 16; i++) begin
      envs[i] = ($urandom_range(0, 1)) ? 31'($urandom) : 31'($urandom_range(0, 3));
      epis[i] = ($urandom_range(0, 1)) ? 31'($urandom) : 31'(i);
    end
    send_request(ergf_pkg::MODE_CLEAR, 31'($urandom), 31'($urandom), $urandom);
    for (int r = 0; r < rows; r++) begin
      k = $urandom_range(0, pool - 1);
      if ($urandom_range(0, 15) == 0)
        send_request(2'($urandom), 31'($urandom), 31'($urandom), rand_reward());
      else
        send_request(ergf_pkg::MODE_ACCUM, envs[k], epis[k], rand_reward());
    end
    send_request(ergf_pkg::MODE_FINALIZE, 31'($urandom), 31'($urandom), $urandom);
    for (int r = 0; r < rows / 2 + 2; r++) begin
      k = $urandom_range(0, pool);
      if (k == pool)
        send_request(ergf_pkg::MODE_CLASSIFY, 31'($urandom), 31'($urandom), $urandom);
      else
        send_request(ergf_pkg::MODE_CLASSIFY, envs[k], epis[k], $urandom);
    end
  endtask

  initial begin
    calm = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = ergf_pkg::CFG_FILTER_MODE;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset defaults, key extremes, reward extremes
    send_request(ergf_pkg::MODE_CLASSIFY, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd0);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_ACCUM, 31'd0, 31'd0, 32'h7FFF_FFFF);
    send_request(ergf_pkg::MODE_ACCUM, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000);
    send_request(ergf_pkg::MODE_ACCUM, 31'd0, 31'h7FFF_FFFF, 32'h0001_0000);
    send_request(ergf_pkg::MODE_ACCUM, 31'd0, 31'd0, 32'h7FFF_FFFF);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_CLASSIFY, 31'd0, 31'd0, '0);
    send_request(ergf_pkg::MODE_CLASSIFY, 31'd5, 31'd5, '0);
    // top count mode, ties, zero top count is rejected
    set_filter(ergf_pkg::FILT_TOP, '0, '0, 9'd0);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    set_filter(ergf_pkg::FILT_TOP, '0, '0, 9'd256);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_ACCUM, 31'd9, 31'd9, 32'h0001_0000);
    set_filter(ergf_pkg::FILT_TOP, '0, '0, 9'd1);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_CLASSIFY, 31'd0, 31'h7FFF_FFFF, '0);
    // range mode with floor above ceiling is rejected
    set_filter(ergf_pkg::FILT_RANGE, 48'h0000_0001_0000, 48'h0000_0000_0000, 9'd1);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    set_filter(ergf_pkg::FILT_RANGE, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 9'h1FF);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    set_filter(ergf_pkg::FILT_FLOOR, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 9'd1);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_CLASSIFY, 31'd0, 31'd0, '0);
    send_request(ergf_pkg::MODE_CLEAR, '0, '0, '0);

    // fill the table, then one more key reports table full
    for (int i = 0; i < 256; i++)
      send_request(ergf_pkg::MODE_ACCUM, 31'(i), 31'(i ^ 7), rand_reward());
    send_request(ergf_pkg::MODE_ACCUM, 31'd999, 31'd999, 32'd1);
    send_request(ergf_pkg::MODE_ACCUM, 31'd3, 31'd4, 32'd1);
    // pause until every result is in
    idle_input();
    while (pending != 0) @(negedge clk);
    set_filter(ergf_pkg::FILT_TOP, '0, '0, 9'd100);
    send_request(ergf_pkg::MODE_FINALIZE, '0, '0, '0);
    send_request(ergf_pkg::MODE_CLASSIFY, 31'd7, 31'd0, '0);

    // random phases over all filter settings
    for (int ph = 0; ph < 20; ph++) begin
      if (ph == 16) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: set_filter(ergf_pkg::FILT_ALL, 48'($urandom), 48'($urandom), 9'($urandom));
        1: set_filter(ergf_pkg::FILT_FLOOR,
                      {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom},
                      48'($urandom), 9'($urandom_range(0, 3)));
        2: set_filter(ergf_pkg::FILT_TOP, 48'($urandom), 48'($urandom),
                      9'($urandom_range(0, 12)));
        default: set_filter(ergf_pkg::FILT_RANGE,
                            {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom},
                            {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, $urandom},
                            9'($urandom_range(1, 511)));
      endcase
      run_episode_set($urandom_range(20, 50), $urandom_range(2, 16));
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/ergf_pkg.sv
rtl/core/ergf_cell.sv
rtl/core/episode_return_group_filter.sv
tb/ergf_checker.sv
tb/tb.sv
